// ===== hw/rtl/link_rendezvous_tracker_assert.svh =====
// Assertion macros used by the rendezvous tracker control module
`ifndef LINK_RENDEZVOUS_TRACKER_ASSERT_SVH
`define LINK_RENDEZVOUS_TRACKER_ASSERT_SVH

// Antecedent and consequent in the same cycle
`define LRT_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rendezvous tracker: same-cycle check failed");

// Consequent in the cycle after the antecedent
`define LRT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rendezvous tracker: next-cycle check failed");

`endif

// ===== hw/rtl/lrt_pkg.sv =====
package lrt_pkg;

   // Default sizing
   localparam int NODES_DEF      = 8;
   localparam int PACKET_MAX_DEF = 32768;

   // Transaction actions
   localparam logic [1:0] ACT_FRAME_START  = 2'd0;
   localparam logic [1:0] ACT_DATAGRAM     = 2'd1;
   localparam logic [1:0] ACT_FRAME_FINISH = 2'd2;
   localparam logic [1:0] ACT_WORD_WRITE   = 2'd3;

   // Link modes
   localparam logic [1:0] MODE_OFF   = 2'd0;
   localparam logic [1:0] MODE_PROBE = 2'd1;
   localparam logic [1:0] MODE_LINK  = 2'd2;

   // Register indexes
   localparam logic [1:0] CSR_LINK_MODE   = 2'd0;
   localparam logic [1:0] CSR_OWN_NODE    = 2'd1;
   localparam logic [1:0] CSR_NODE_TOTAL  = 2'd2;
   localparam logic [1:0] CSR_STALE_LIMIT = 2'd3;

   // Rendezvous word layout
   localparam int GRP_W      = 16;
   localparam int GRP_READY  = 0;
   localparam int GRP_LINKED = 16;
   localparam int GRP_ACK    = 32;
   localparam int GRP_BOOTED = 48;

   localparam logic [7:0]  RX_MAGIC  = 8'h43;
   localparam logic [16:0] HDR_BYTES = 17'd6;

   // Flag bits
   localparam int BIT_READY  = 0;
   localparam int BIT_ACK    = 1;
   localparam int BIT_BOOTED = 2;

   typedef struct packed {
      logic capture;
      logic exec;
      logic walk_rd;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic walk_needed;
      logic walk_last;
   } sts_type;

endpackage

// ===== hw/rtl/lrt_datapath.sv =====
module lrt_datapath import lrt_pkg::*; #(
   parameter int NODES      = NODES_DEF,
   parameter int PACKET_MAX = PACKET_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wr_data,
   input  logic [1:0]  req_action,
   input  logic        req_link_ready,
   input  logic [15:0] req_board_packet_size,
   input  logic [7:0]  req_rx_magic,
   input  logic [7:0]  req_rx_node,
   input  logic [2:0]  req_rx_flags,
   input  logic [15:0] req_rx_size,
   input  logic [15:0] req_rx_length,
   input  logic [63:0] req_module_word,
   output logic [63:0] rsp_rendezvous,
   output logic        rsp_send_valid,
   output logic [2:0]  rsp_send_flags,
   output logic [15:0] rsp_send_size,
   output logic        rsp_size_oversize,
   output logic        rsp_rx_accepted,
   output logic        rsp_rx_store,
   input  cmd_type     cmd,
   output sts_type     sts
);

   localparam int IW = $clog2(NODES);
   localparam int RW = IW + 1;
   localparam logic [15:0] PMAX = 16'(PACKET_MAX);

   // Configuration
   logic [1:0]  link_mode_ff;
   logic [2:0]  own_node_ff;
   logic [3:0]  node_total_ff;
   logic [7:0]  stale_limit_ff;

   // Captured transaction
   logic [1:0]  act_ff;
   logic        link_ready_ff;
   logic [15:0] packet_ff;
   logic [7:0]  magic_ff;
   logic [7:0]  node_ff;
   logic [2:0]  flags_ff;
   logic [15:0] size_ff;
   logic [15:0] length_ff;
   logic [63:0] mword_ff;

   // Tracker state
   logic [63:0]      word_ff, word_in;
   logic [31:0]      frame_count_ff;
   logic             ingest_ff, ingest_in;
   logic [NODES-1:0] ever_ff;
   logic [31:0]      last_mem [NODES];
   logic [31:0]      rd_ff;
   logic [IW-1:0]    walk_idx_ff;
   logic [IW-1:0]    chk_idx_ff;
   logic             chk_v_ff;

   // Result scratch
   logic        res_send_valid_ff, res_send_valid_in;
   logic [2:0]  res_flags_ff, res_flags_in;
   logic [15:0] res_size_ff, res_size_in;
   logic        res_over_ff, res_over_in;
   logic        res_acc_ff, res_acc_in;
   logic        res_store_ff, res_store_in;

   logic          active;
   logic [RW-1:0] ring;
   logic [16:0]   ring_mask_wide;
   logic [15:0]   ring_mask;
   logic [15:0]   own_mask;
   logic [15:0]   node_mask;
   logic [15:0]   chk_mask;
   logic [15:0]   w_ready, w_linked, w_ack, w_booted;
   logic [15:0]   fs_ready, fs_linked;
   logic [15:0]   dg_ready, dg_linked;
   logic          own_ack, own_booted;
   logic          dg_ok;
   logic          send_now;
   logic [31:0]   age;
   logic          chk_clear;

   assign active = (link_mode_ff == MODE_PROBE) || (link_mode_ff == MODE_LINK);
   assign ring   = ({1'b0, node_total_ff} > 5'(NODES)) ? RW'(NODES) : RW'(node_total_ff);

   assign ring_mask_wide = (17'(1) << ring) - 17'(1);
   assign ring_mask      = ring_mask_wide[15:0];
   assign own_mask       = 16'(1) << own_node_ff;
   assign node_mask      = 16'(1) << node_ff[IW-1:0];
   assign chk_mask       = 16'(1) << chk_idx_ff;

   assign w_ready  = word_ff[GRP_READY  +: GRP_W];
   assign w_linked = word_ff[GRP_LINKED +: GRP_W];
   assign w_ack    = word_ff[GRP_ACK    +: GRP_W];
   assign w_booted = word_ff[GRP_BOOTED +: GRP_W];

   assign own_ack    = |(w_ack & own_mask);
   assign own_booted = |(w_booted & own_mask);

   always_comb begin
      fs_ready  = w_ready | own_mask;
      fs_linked = w_linked | (own_booted ? own_mask : 16'd0);
      // probe mode fakes every ring member as present
      if (link_mode_ff == MODE_PROBE) begin
         fs_ready  = fs_ready | ring_mask;
         fs_linked = fs_linked | ring_mask;
      end
   end

   assign dg_ok = ingest_ff && (link_mode_ff == MODE_LINK) &&
                  ({1'b0, length_ff} >= HDR_BYTES) && (magic_ff == RX_MAGIC) &&
                  (node_ff < 8'(ring)) && (node_ff != {5'd0, own_node_ff}) &&
                  (size_ff <= PMAX) &&
                  ({1'b0, length_ff} >= (HDR_BYTES + {1'b0, size_ff}));

   assign dg_ready  = (w_ready & ~node_mask) | (flags_ff[BIT_READY] ? node_mask : 16'd0);
   assign dg_linked = (w_linked & ~node_mask) | (flags_ff[BIT_BOOTED] ? node_mask : 16'd0);

   assign send_now = (act_ff == ACT_FRAME_START) && (link_mode_ff == MODE_LINK) && link_ready_ff;

   // Peer age check, one peer per cycle behind the memory read
   assign age       = frame_count_ff - rd_ff;
   assign chk_clear = chk_v_ff && ever_ff[chk_idx_ff] && ((chk_mask & own_mask) == 16'd0) &&
                      (age > {24'd0, stale_limit_ff});

   assign sts.walk_needed = (act_ff == ACT_FRAME_FINISH) && active && ingest_ff &&
                            (ring != RW'(0));
   assign sts.walk_last   = ((RW'(walk_idx_ff) + RW'(1)) == ring);

   always_comb begin
      word_in   = word_ff;
      ingest_in = ingest_ff;
      if (cmd.exec) begin
         case (act_ff)
            ACT_FRAME_START: begin
               if (active) begin
                  word_in[GRP_READY  +: GRP_W] = fs_ready;
                  word_in[GRP_LINKED +: GRP_W] = fs_linked;
                  ingest_in = (link_mode_ff == MODE_LINK) && link_ready_ff;
               end
            end
            ACT_DATAGRAM: begin
               if (dg_ok) begin
                  word_in[GRP_READY  +: GRP_W] = dg_ready;
                  word_in[GRP_LINKED +: GRP_W] = dg_linked;
               end
            end
            ACT_FRAME_FINISH: begin
               if (active) begin
                  ingest_in = 1'b0;
               end
            end
            default: begin
               word_in = mword_ff;
            end
         endcase
      end else if (chk_clear) begin
         word_in[GRP_READY +: GRP_W] = w_ready & ~chk_mask;
      end
   end

   always_comb begin
      res_send_valid_in = send_now;
      res_flags_in      = send_now ? {own_booted, own_ack, 1'b1} : 3'd0;
      res_size_in       = (send_now && (packet_ff != 16'd0) && (packet_ff <= PMAX)) ?
                          packet_ff : 16'd0;
      res_over_in       = send_now && (packet_ff > PMAX);
      res_acc_in        = (act_ff == ACT_DATAGRAM) && dg_ok;
      res_store_in      = res_acc_in && (size_ff != 16'd0);
   end

   // Configuration, control state
   always_ff @(posedge clock) begin
      if (reset) begin
         link_mode_ff   <= MODE_OFF;
         own_node_ff    <= 3'd0;
         node_total_ff  <= 4'd2;
         stale_limit_ff <= 8'd6;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_LINK_MODE:   link_mode_ff   <= csr_wr_data[1:0];
            CSR_OWN_NODE:    own_node_ff    <= csr_wr_data[2:0];
            CSR_NODE_TOTAL:  node_total_ff  <= csr_wr_data[3:0];
            CSR_STALE_LIMIT: stale_limit_ff <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff        <= 64'd0;
         frame_count_ff <= 32'd0;
         ingest_ff      <= 1'b0;
         ever_ff        <= '0;
         chk_v_ff       <= 1'b0;
         walk_idx_ff    <= '0;
      end else begin
         word_ff   <= word_in;
         ingest_ff <= ingest_in;
         chk_v_ff  <= cmd.walk_rd;
         if (cmd.exec && (act_ff == ACT_FRAME_START) && active) begin
            frame_count_ff <= frame_count_ff + 32'd1;
         end
         if (cmd.exec && res_store_in) begin
            ever_ff[node_ff[IW-1:0]] <= 1'b1;
         end
         if (cmd.exec) begin
            walk_idx_ff <= '0;
         end else if (cmd.walk_rd) begin
            walk_idx_ff <= walk_idx_ff + IW'(1);
         end
      end
   end

   // Last payload frame per peer
   always_ff @(posedge clock) begin
      if (cmd.exec && res_store_in) begin
         last_mem[node_ff[IW-1:0]] <= frame_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_rd) begin
         rd_ff      <= last_mem[walk_idx_ff];
         chk_idx_ff <= walk_idx_ff;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff        <= req_action;
         link_ready_ff <= req_link_ready;
         packet_ff     <= req_board_packet_size;
         magic_ff      <= req_rx_magic;
         node_ff       <= req_rx_node;
         flags_ff      <= req_rx_flags;
         size_ff       <= req_rx_size;
         length_ff     <= req_rx_length;
         mword_ff      <= req_module_word;
      end
      if (cmd.exec) begin
         res_send_valid_ff <= res_send_valid_in;
         res_flags_ff      <= res_flags_in;
         res_size_ff       <= res_size_in;
         res_over_ff       <= res_over_in;
         res_acc_ff        <= res_acc_in;
         res_store_ff      <= res_store_in;
      end
      if (cmd.load_rsp) begin
         rsp_rendezvous    <= word_ff;
         rsp_send_valid    <= res_send_valid_ff;
         rsp_send_flags    <= res_flags_ff;
         rsp_send_size     <= res_size_ff;
         rsp_size_oversize <= res_over_ff;
         rsp_rx_accepted   <= res_acc_ff;
         rsp_rx_store      <= res_store_ff;
      end
   end

endmodule

// ===== hw/rtl/lrt_ctrl.sv =====
`include "link_rendezvous_tracker_assert.svh"

module lrt_ctrl import lrt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EXEC  = 3'd1;
   localparam logic [2:0] ST_WALK  = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = sts.walk_needed ? ST_WALK : ST_DONE;
         end
         ST_WALK: begin
            cmd.walk_rd = 1'b1;
            if (sts.walk_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last peer check lands this cycle
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `LRT_ASSERT_IMPLIES(a_load_into_free_slot, clock, reset, cmd.load_rsp, !rsp_valid_ff || rsp_ready)
   `LRT_ASSERT_NEXT(a_accept_then_exec, clock, reset, req_valid && req_ready, state_ff == ST_EXEC)
   `LRT_ASSERT_NEXT(a_walk_then_drain, clock, reset, cmd.walk_rd && sts.walk_last, state_ff == ST_DRAIN)
   `LRT_ASSERT_NEXT(a_load_shows_result, clock, reset, cmd.load_rsp, rsp_valid_ff)

endmodule

// ===== hw/rtl/link_rendezvous_tracker.sv =====
// Channel  Handshake             Payload
// req_     req_valid/req_ready   action, link flag, packet size, datagram header, word
// rsp_     rsp_valid/rsp_ready   rendezvous word, send header, datagram verdict
// csr_     csr_wr_en             csr_index, csr_wr_data (no read-back)
//
// A result is presented once its transaction has passed the EXEC and DONE states,
// and the next transaction is taken only once the block is back in IDLE. A frame finish
// with ingest open also passes the WALK and DRAIN states between EXEC and DONE, as the
// peer age walk reads one last-receive entry per cycle from the timer memory.
// Reset is synchronous and restores the word, counters, seen flags and configuration registers.
// The next transaction is accepted while a result waits in the output register;
// a stalled result holds the block only once the following one is finished.
module link_rendezvous_tracker import lrt_pkg::*; #(
   parameter int NODES      = NODES_DEF,
   parameter int PACKET_MAX = PACKET_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic        req_link_ready,
   input  logic [15:0] req_board_packet_size,
   input  logic [7:0]  req_rx_magic,
   input  logic [7:0]  req_rx_node,
   input  logic [2:0]  req_rx_flags,
   input  logic [15:0] req_rx_size,
   input  logic [15:0] req_rx_length,
   input  logic [63:0] req_module_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_rendezvous,
   output logic        rsp_send_valid,
   output logic [2:0]  rsp_send_flags,
   output logic [15:0] rsp_send_size,
   output logic        rsp_size_oversize,
   output logic        rsp_rx_accepted,
   output logic        rsp_rx_store
);

   cmd_type cmd;
   sts_type sts;

   lrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lrt_datapath #(
      .NODES      (NODES),
      .PACKET_MAX (PACKET_MAX)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wr_data           (csr_wr_data),
      .req_action            (req_action),
      .req_link_ready        (req_link_ready),
      .req_board_packet_size (req_board_packet_size),
      .req_rx_magic          (req_rx_magic),
      .req_rx_node           (req_rx_node),
      .req_rx_flags          (req_rx_flags),
      .req_rx_size           (req_rx_size),
      .req_rx_length         (req_rx_length),
      .req_module_word       (req_module_word),
      .rsp_rendezvous        (rsp_rendezvous),
      .rsp_send_valid        (rsp_send_valid),
      .rsp_send_flags        (rsp_send_flags),
      .rsp_send_size         (rsp_send_size),
      .rsp_size_oversize     (rsp_size_oversize),
      .rsp_rx_accepted       (rsp_rx_accepted),
      .rsp_rx_store          (rsp_rx_store),
      .cmd                   (cmd),
      .sts                   (sts)
   );

endmodule
